// ===== hw/rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int ID_W    = 4;
  localparam int DELTA_W = 16;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_POP    = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FIN_A,
    S_FIN_B,
    S_POP
  } state_t;

  // One result as the controller hands it to the output stage.
  typedef struct packed {
    logic               valid;
    status_t            status;
    logic [ID_W-1:0]    popped_id;
    logic [DELTA_W-1:0] popped_delta;
    logic               now_empty;
  } res_t;

endpackage

// ===== hw/rtl/delta_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// delta_timer_queue_core
// Delta-list timer queue with one slot per process id: insert by delay,
// pop of the head entry.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                          Transfer
//   command   start, in_func, in_proc_id, in_delay           start & !busy
//   result    out_valid, out_status, out_popped_id,          out_valid, one cycle
//             out_popped_delta, out_now_empty
//
// An empty pop or an ignored insert answers in the transfer cycle; a pop
// reads the head entry and unlinks it in S_POP. An insert walks the list
// in S_WALK, one read of the link and delta memories per step, and then
// writes in S_FIN_A and S_FIN_B. The result is on the outputs in the
// cycle right after the last cycle of the operation.
// Reset (synchronous, rst_n low) empties the queue; the memories need no
// clearing. The receiver cannot stall, so results never back up.
//
module delta_timer_queue_core #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [dtq_pkg::ID_W-1:0]      in_proc_id,
  input  logic [dtq_pkg::DELTA_W-1:0]   in_delay,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [dtq_pkg::ID_W-1:0]      out_popped_id,
  output logic [dtq_pkg::DELTA_W-1:0]   out_popped_delta,
  output logic                          out_now_empty
);

  import dtq_pkg::*;

  res_t               res;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [ID_W-1:0]    out_popped_id_r;
  logic [DELTA_W-1:0] out_popped_delta_r;
  logic               out_now_empty_r;

  dtq_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_func    (in_func),
    .in_proc_id (in_proc_id),
    .in_delay   (in_delay),
    .busy       (busy),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r       <= 2'(res.status);
      out_popped_id_r    <= res.popped_id;
      out_popped_delta_r <= res.popped_delta;
      out_now_empty_r    <= res.now_empty;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_id    = out_popped_id_r;
  assign out_popped_delta = out_popped_delta_r;
  assign out_now_empty    = out_now_empty_r;

endmodule

// ===== hw/rtl/dtq_ram.sv =====
// ----------------------------------------------------------------------------
// dtq_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl
// Walk and update sequencer: holds the head pointer and the per-slot queued
// flags, and reads, modifies and writes the link and delta memories.
// ----------------------------------------------------------------------------
module dtq_ctrl #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          in_func,
  input  logic [dtq_pkg::ID_W-1:0]      in_proc_id,
  input  logic [dtq_pkg::DELTA_W-1:0]   in_delay,
  output logic                          busy,
  output dtq_pkg::res_t                 res
);

  import dtq_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int LINK_W = $clog2(NUM_SLOTS + 1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_SLOTS);

  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [DELTA_W-1:0]   rest_r, rest_nxt;
  logic [SLOT_W-1:0]    cur_r, cur_nxt;
  logic [SLOT_W-1:0]    prev_r, prev_nxt;
  logic                 have_prev_r, have_prev_nxt;
  logic                 cur_ok_r, cur_ok_nxt;
  logic [DELTA_W-1:0]   cur_delta_r, cur_delta_nxt;
  logic [LINK_W-1:0]    steps_r, steps_nxt;
  logic [SLOT_W-1:0]    head_r, head_nxt;
  logic                 head_valid_r, head_valid_nxt;
  logic [NUM_SLOTS-1:0] queued_r, queued_nxt;

  logic                 link_we, delta_we;
  logic [SLOT_W-1:0]    link_waddr, delta_waddr, rd_addr;
  logic [LINK_W-1:0]    link_wdata, link_rdata;
  logic [DELTA_W-1:0]   delta_wdata, delta_rdata;

  logic [SLOT_W-1:0]    in_slot;
  logic                 id_ok;
  logic                 link_ok;

  dtq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(LINK_W)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  dtq_ram #(.DEPTH(NUM_SLOTS), .WIDTH(DELTA_W)) u_delta_ram (
    .clk   (clk),
    .we    (delta_we),
    .waddr (delta_waddr),
    .wdata (delta_wdata),
    .raddr (rd_addr),
    .rdata (delta_rdata)
  );

  assign in_slot = SLOT_W'(in_proc_id);
  assign id_ok   = (32'(in_proc_id) < NUM_SLOTS);
  assign link_ok = (32'(link_rdata) < NUM_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      head_valid_r <= 1'b0;
      queued_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      head_valid_r <= head_valid_nxt;
      queued_r     <= queued_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    rest_r      <= rest_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    cur_ok_r    <= cur_ok_nxt;
    cur_delta_r <= cur_delta_nxt;
    steps_r     <= steps_nxt;
  end

  // The memories are touched by one state at a time and every read is issued
  // in the cycle before its data is used, so no entry is read while a write
  // to it is still pending.
  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    rest_nxt       = rest_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    cur_ok_nxt     = cur_ok_r;
    cur_delta_nxt  = cur_delta_r;
    steps_nxt      = steps_r;
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    queued_nxt     = queued_r;
    busy           = (state_r != S_IDLE);
    rd_addr        = cur_r;
    link_we        = 1'b0;
    link_waddr     = slot_r;
    link_wdata     = LINK_NONE;
    delta_we       = 1'b0;
    delta_waddr    = slot_r;
    delta_wdata    = rest_r;
    res            = '0;
    res.status     = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == FUNC_POP) begin
            if (!head_valid_r) begin
              res.valid     = 1'b1;
              res.status    = ST_EMPTY;
              res.now_empty = 1'b1;
            end else begin
              rd_addr   = head_r;
              state_nxt = S_POP;
            end
          end else if (!id_ok || queued_r[in_slot]) begin
            res.valid     = 1'b1;
            res.status    = ST_DUP;
            res.now_empty = !head_valid_r;
          end else begin
            slot_nxt      = in_slot;
            rest_nxt      = in_delay;
            have_prev_nxt = 1'b0;
            steps_nxt     = '0;
            cur_nxt       = head_r;
            rd_addr       = head_r;
            if (head_valid_r) begin
              state_nxt = S_WALK;
            end else begin
              cur_ok_nxt = 1'b0;
              state_nxt  = S_FIN_A;
            end
          end
        end
      end

      S_WALK: begin
        if (rest_r > delta_rdata && 32'(steps_r) < NUM_SLOTS) begin
          rest_nxt      = rest_r - delta_rdata;
          prev_nxt      = cur_r;
          have_prev_nxt = 1'b1;
          steps_nxt     = steps_r + LINK_W'(1);
          if (link_ok) begin
            cur_nxt = SLOT_W'(link_rdata);
            rd_addr = SLOT_W'(link_rdata);
          end else begin
            cur_ok_nxt = 1'b0;
            state_nxt  = S_FIN_A;
          end
        end else begin
          cur_ok_nxt    = 1'b1;
          cur_delta_nxt = delta_rdata;
          state_nxt     = S_FIN_A;
        end
      end

      S_FIN_A: begin
        link_we            = 1'b1;
        link_wdata         = cur_ok_r ? LINK_W'(cur_r) : LINK_NONE;
        delta_we           = 1'b1;
        queued_nxt[slot_r] = 1'b1;
        state_nxt          = S_FIN_B;
      end

      S_FIN_B: begin
        if (have_prev_r) begin
          link_we    = 1'b1;
          link_waddr = prev_r;
          link_wdata = LINK_W'(slot_r);
        end else begin
          head_nxt       = slot_r;
          head_valid_nxt = 1'b1;
        end
        if (cur_ok_r) begin
          delta_we    = 1'b1;
          delta_waddr = cur_r;
          delta_wdata = cur_delta_r - rest_r;
        end
        res.valid = 1'b1;
        state_nxt = S_IDLE;
      end

      S_POP: begin
        link_we            = 1'b1;
        link_waddr         = head_r;
        queued_nxt[head_r] = 1'b0;
        if (link_ok) begin
          head_nxt       = SLOT_W'(link_rdata);
          head_valid_nxt = 1'b1;
        end else begin
          head_nxt       = '0;
          head_valid_nxt = 1'b0;
        end
        res.valid        = 1'b1;
        res.popped_id    = ID_W'(head_r);
        res.popped_delta = delta_rdata;
        res.now_empty    = !link_ok;
        state_nxt        = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The first insert into an empty queue flags its slot in S_FIN_A but makes the
  // head valid only in S_FIN_B, so the check only applies between operations.
  a_empty_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && !head_valid_r) |-> (queued_r == '0))
    else $error("queue marked empty while a slot is flagged as queued");

  a_head_queued: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_r |-> queued_r[head_r])
    else $error("head slot is not flagged as queued");

  a_walk_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !queued_r[slot_r])
    else $error("insert walk running for a slot that is already queued");

  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> !queued_r[$past(head_r)])
    else $error("popped slot still flagged as queued");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (32'(steps_r) < NUM_SLOTS))
    else $error("insert walk visited more entries than there are slots");

endmodule
